// ===== src/tnaa_pkg.sv =====
`default_nettype none
package tnaa_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int IN_W  = 288;
  localparam int OUT_W = 368;

  localparam int ACC_W = 128;
  localparam int MA_W  = 80;
  localparam int MB_W  = 64;
  localparam int CNT_W = 7;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
    cnt_t            nbits;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic             sqrt_mode;
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] d;
    cnt_t             nsteps;
  } csu_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] q;
  } csu_rsp_t;

endpackage
`default_nettype wire

// ===== src/tnaa_mul.sv =====
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle.
module tnaa_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tnaa_pkg::mul_req_t req,
  output tnaa_pkg::mul_rsp_t      rsp
);
  import tnaa_pkg::*;

  logic             busy_r;
  logic             done_r;
  cnt_t             cnt_r;
  logic [ACC_W-1:0] a_r;
  logic [ACC_W-1:0] p_r;
  logic [MB_W-1:0]  b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == cnt_t'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= ACC_W'(req.a);
      b_r <= req.b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= p_r + (b_r[0] ? a_r : '0);
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule
`default_nettype wire

// ===== src/tnaa_csu.sv =====
`default_nettype none
// Compare-subtract unit: restoring division (one quotient bit per cycle)
// or integer square root (one result bit per cycle).
module tnaa_csu (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tnaa_pkg::csu_req_t req,
  output tnaa_pkg::csu_rsp_t      rsp
);
  import tnaa_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic             mode_r;
  cnt_t             cnt_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] dv_r;
  logic [ACC_W-1:0] q_r;

  logic [ACC_W-1:0] cmp;
  logic [ACC_W-1:0] diff;
  logic             ge;

  always_comb begin
    cmp  = mode_r ? (q_r + dv_r) : dv_r;
    ge   = (acc_r >= cmp);
    diff = acc_r - cmp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nsteps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == cnt_t'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.sqrt_mode;
      acc_r  <= req.x;
      dv_r   <= req.d;
      q_r    <= '0;
    end else if (busy_r) begin
      if (ge) acc_r <= diff;
      if (mode_r) begin
        q_r  <= ge ? ((q_r >> 1) + dv_r) : (q_r >> 1);
        dv_r <= dv_r >> 2;
      end else begin
        q_r  <= {q_r[ACC_W-2:0], ge};
        dv_r <= dv_r >> 1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule
`default_nettype wire

// ===== src/triangle_normal_area_accumulator_core.sv =====
`default_nettype none
// Triangle normal / centroid / area engine with running surface and volume
// totals. One triangle per input transaction, one result per triangle.
// Every product goes through one bit-serial shift-add multiplier (one bit a
// cycle), the centroid divisions by three are reciprocal multiplications on
// that same multiplier, and the root and the three normal divisions go
// through one compare-subtract unit (one bit a cycle); the sequencer steps
// these one after the other. in_tready is high only between triangles. A
// finished result waits in an output register so the next triangle can be
// taken while it is pending. in_tuser = 1 clears both totals before the
// triangle is counted. Totals saturate.
module triangle_normal_area_accumulator_core #(
  parameter int FRAC_BITS = tnaa_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // ax, ay, az, bx, by, bz, cx_in, cy_in, cz_in (32 bits each)
  input  wire logic [tnaa_pkg::IN_W-1:0]  in_tdata,
  // first_of_mesh
  input  wire logic                       in_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // unit_nx, unit_ny, unit_nz, centroid_x, centroid_y, centroid_z (32 each),
  // tri_area (48), surface_sum (63), volume_sum (64), one zero pad bit
  output logic [tnaa_pkg::OUT_W-1:0]      out_tdata
);
  import tnaa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CEN   = 9'b000000010,
    S_CROSS = 9'b000000100,
    S_SQ    = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_NORM  = 9'b000100000,
    S_VOL1  = 9'b001000000,
    S_VOL2  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;
  // x/3 as (x * ceil(2^36/3)) >> 36, exact for x < 2^35
  localparam logic [34:0]        RECIP3 = 35'd22906492246;

  state_t state_r;
  logic   wait_r;
  logic [1:0] k_r;
  logic   j_r;

  logic signed [32:0] e_r   [6];  // ux uy uz vx vy vz
  logic signed [33:0] vs_r  [3];
  logic signed [31:0] cen_r [3];
  logic signed [66:0] n_r   [3];
  logic signed [66:0] pa_r;
  logic [ACC_W-1:0]   sum_r;
  logic [66:0]        len_r;
  logic signed [31:0] un_r  [3];
  logic [47:0]        area_r;
  logic [MA_W-1:0]    p1_r;
  logic [62:0]        surf_r;
  logic signed [63:0] vol_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  csu_req_t creq;
  csu_rsp_t crsp;

  tnaa_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  tnaa_csu u_csu (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  // ---------------- input unpack ----------------
  logic signed [31:0] vin [9];
  logic signed [32:0] e_in [6];
  logic signed [33:0] vs_in [3];

  always_comb begin
    for (int i = 0; i < 9; i++) vin[i] = in_tdata[32*i +: 32];
    for (int i = 0; i < 3; i++) begin
      e_in[i]   = {vin[3+i][31], vin[3+i]} - {vin[i][31], vin[i]};
      e_in[3+i] = {vin[6+i][31], vin[6+i]} - {vin[i][31], vin[i]};
      vs_in[i]  = {{2{vin[i][31]}}, vin[i]} + {{2{vin[3+i][31]}}, vin[3+i]}
                + {{2{vin[6+i][31]}}, vin[6+i]};
    end
  end

  // ---------------- datapath helpers ----------------
  logic signed [32:0] op_p, op_q;
  logic [32:0]        mag_p, mag_q;
  logic               psgn;
  logic [64:0]        pmag;
  logic signed [66:0] ps;
  logic [66:0]        nmag [3];
  logic               t4;
  logic [66:0]        nmk;
  logic [61:0]        csq;
  logic signed [33:0] vsk;
  logic [33:0]        vabs;
  logic [66:0]        len_nxt;
  logic [30:0]        uval;
  logic signed [31:0] un_nxt;
  logic [33:0]        cq;
  logic signed [31:0] cen_nxt;
  logic [66:0]        aw;
  logic [47:0]        area_nxt;
  logic [63:0]        ssum;
  logic [62:0]        surf_nxt;
  logic [ACC_W-1:0]   pv;
  logic               vneg;
  logic signed [63:0] vterm;
  logic signed [64:0] vsum;
  logic signed [63:0] vol_nxt;
  logic [31:0]        cabs;
  logic [30:0]        uabs;

  always_comb begin
    unique case ({k_r, j_r})
      3'b000:  begin op_p = e_r[1]; op_q = e_r[5]; end
      3'b001:  begin op_p = e_r[2]; op_q = e_r[4]; end
      3'b010:  begin op_p = e_r[2]; op_q = e_r[3]; end
      3'b011:  begin op_p = e_r[0]; op_q = e_r[5]; end
      3'b100:  begin op_p = e_r[0]; op_q = e_r[4]; end
      3'b101:  begin op_p = e_r[1]; op_q = e_r[3]; end
      default: begin op_p = e_r[0]; op_q = e_r[0]; end
    endcase
    mag_p = op_p[32] ? 33'(-op_p) : 33'(op_p);
    mag_q = op_q[32] ? 33'(-op_q) : 33'(op_q);
    psgn  = op_p[32] ^ op_q[32];
    pmag  = mrsp.p[64:0];
    ps    = psgn ? -$signed({2'b00, pmag}) : $signed({2'b00, pmag});

    t4 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      nmag[i] = n_r[i][66] ? 67'(-n_r[i]) : 67'(n_r[i]);
      if (nmag[i][66:62] != '0) t4 = 1'b1;
    end
    unique case (k_r)
      2'd0:    begin nmk = nmag[0]; vsk = vs_r[0]; end
      2'd1:    begin nmk = nmag[1]; vsk = vs_r[1]; end
      2'd2:    begin nmk = nmag[2]; vsk = vs_r[2]; end
      default: begin nmk = nmag[0]; vsk = vs_r[0]; end
    endcase
    csq  = t4 ? nmk[65:4] : nmk[61:0];
    vabs = vsk[33] ? 34'(-vsk) : 34'(vsk);

    len_nxt = (t4 ? {crsp.q[62:0], 4'b0000} : {4'b0000, crsp.q[62:0]}) + 67'd1;

    // normal component: saturate past unity
    if (crsp.q[ACC_W-1:31] != '0 || crsp.q[30:0] > 31'h4000_0000) uval = 31'h4000_0000;
    else uval = crsp.q[30:0];
    un_nxt = (n_r[k_r][66]) ? -$signed({1'b0, uval}) : $signed({1'b0, uval});

    cq      = mrsp.p[69:36];
    cen_nxt = vsk[33] ? 32'(-cq) : cq[31:0];

    aw       = len_r >> (FRAC_BITS + 1);
    area_nxt = (aw[66:48] != '0) ? 48'hFFFF_FFFF_FFFF : aw[47:0];
    ssum     = {1'b0, surf_r} + {16'h0000, area_nxt};
    surf_nxt = ssum[63] ? 63'h7FFF_FFFF_FFFF_FFFF : ssum[62:0];

    cabs = cen_r[0][31] ? 32'(-cen_r[0]) : 32'(cen_r[0]);
    uabs = un_r[0][31] ? 31'(-un_r[0]) : un_r[0][30:0];

    pv   = mrsp.p >> (FRAC_BITS + 30);
    vneg = (cen_r[0][31] ^ un_r[0][31]) && (pv != '0);
    if (vneg) vterm = (pv[ACC_W-1:63] != '0) ? VMIN : -$signed(pv[63:0]);
    else      vterm = (pv[ACC_W-1:63] != '0) ? VMAX : $signed(pv[63:0]);
    vsum = {vol_r[63], vol_r} + {vterm[63], vterm};
    if (vsum[64] != vsum[63]) vol_nxt = vsum[64] ? VMIN : VMAX;
    else vol_nxt = vsum[63:0];
  end

  // ---------------- unit requests ----------------
  always_comb begin
    mreq = '0;
    creq = '0;
    unique case (state_r)
      S_CEN: begin
        mreq.start = !wait_r;
        mreq.a     = MA_W'(vabs) + MA_W'(1);
        mreq.b     = MB_W'(RECIP3);
        mreq.nbits = cnt_t'(35);
      end
      S_CROSS: begin
        mreq.start = !wait_r;
        mreq.a     = MA_W'(mag_p);
        mreq.b     = MB_W'(mag_q);
        mreq.nbits = cnt_t'(33);
      end
      S_SQ: begin
        mreq.start = !wait_r;
        mreq.a     = MA_W'(csq);
        mreq.b     = MB_W'(csq);
        mreq.nbits = cnt_t'(62);
      end
      S_ROOT: begin
        creq.start     = !wait_r;
        creq.sqrt_mode = 1'b1;
        creq.x         = sum_r;
        creq.d         = ACC_W'(1) << 126;
        creq.nsteps    = cnt_t'(64);
      end
      S_NORM: begin
        creq.start  = !wait_r;
        creq.x      = (ACC_W'(nmk) << 30) + ACC_W'(len_r >> 1);
        creq.d      = ACC_W'(len_r) << 32;
        creq.nsteps = cnt_t'(33);
      end
      S_VOL1: begin
        mreq.start = !wait_r;
        mreq.a     = MA_W'(area_r);
        mreq.b     = MB_W'(cabs);
        mreq.nbits = cnt_t'(32);
      end
      S_VOL2: begin
        mreq.start = !wait_r;
        mreq.a     = p1_r;
        mreq.b     = MB_W'(uabs);
        mreq.nbits = cnt_t'(31);
      end
      default: begin
        mreq = '0;
        creq = '0;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      k_r         <= '0;
      j_r         <= 1'b0;
      out_valid_r <= 1'b0;
      surf_r      <= '0;
      vol_r       <= '0;
    end else begin
      // S_DONE handles the output register itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      if ((mreq.start || creq.start)) wait_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            for (int i = 0; i < 6; i++) e_r[i] <= e_in[i];
            for (int i = 0; i < 3; i++) vs_r[i] <= vs_in[i];
            if (in_tuser) begin
              surf_r <= '0;
              vol_r  <= '0;
            end
            k_r     <= '0;
            j_r     <= 1'b0;
            state_r <= S_CEN;
          end
        end
        S_CEN: begin
          if (wait_r && mrsp.done) begin
            wait_r     <= 1'b0;
            cen_r[k_r] <= cen_nxt;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_CROSS;
            end else k_r <= k_r + 1'b1;
          end
        end
        S_CROSS: begin
          if (wait_r && mrsp.done) begin
            wait_r <= 1'b0;
            if (!j_r) begin
              pa_r <= ps;
              j_r  <= 1'b1;
            end else begin
              n_r[k_r] <= pa_r - ps;
              j_r      <= 1'b0;
              if (k_r == 2'd2) begin
                k_r     <= '0;
                sum_r   <= '0;
                state_r <= S_SQ;
              end else k_r <= k_r + 1'b1;
            end
          end
        end
        S_SQ: begin
          if (wait_r && mrsp.done) begin
            wait_r <= 1'b0;
            sum_r  <= sum_r + mrsp.p;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= S_ROOT;
            end else k_r <= k_r + 1'b1;
          end
        end
        S_ROOT: begin
          if (wait_r && crsp.done) begin
            wait_r  <= 1'b0;
            len_r   <= len_nxt;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (wait_r && crsp.done) begin
            wait_r    <= 1'b0;
            un_r[k_r] <= un_nxt;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              area_r  <= area_nxt;
              surf_r  <= surf_nxt;
              state_r <= S_VOL1;
            end else k_r <= k_r + 1'b1;
          end
        end
        S_VOL1: begin
          if (wait_r && mrsp.done) begin
            wait_r  <= 1'b0;
            p1_r    <= mrsp.p[MA_W-1:0];
            state_r <= S_VOL2;
          end
        end
        S_VOL2: begin
          if (wait_r && mrsp.done) begin
            wait_r  <= 1'b0;
            vol_r   <= vol_nxt;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {1'b0, vol_r, surf_r, area_r, cen_r[2], cen_r[1], cen_r[0],
                            un_r[2], un_r[1], un_r[0]};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
